// ===== design/ffba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants and controller/datapath command and status types for the
// first-fit bitmap allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // default pool capacity in units
    localparam int POOL_UNITS_DEF = 32768;

    // field widths
    localparam int LEN_W   = 16;
    localparam int START_W = 15;
    localparam int CFG_W   = 16;

    // occupancy map word geometry
    localparam int WORD_W = 32;
    localparam int OFF_W  = 5;

    // pool size after reset
    localparam logic [CFG_W-1:0] POOL_SIZE_RST = 16'd20000;

    // request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic clear;     // write one zero word of the clearing pass
        logic load;      // take the request word
        logic scan;      // scan the map for a free run
        logic mark;      // read-modify-write the latched range
        logic out_load;  // move the result into the output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;   // clearing pass at its last word
        logic in_free;    // request is a free
        logic in_empty;   // request needs no map access
        logic scan_hit;   // fitting run found in this word
        logic scan_miss;  // last word scanned without a fit
        logic mark_done;  // last word of the range written back
    } t_sts;

endpackage
`default_nettype wire

// ===== design/ffba_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_req_if
// Request channel: valid/ready handshake with the allocate or free word.
// ----------------------------------------------------------------------------
interface ffba_req_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [ffba_pkg::LEN_W-1:0]    length;
    logic [ffba_pkg::START_W-1:0]  free_start;

    modport source (output valid, output action, output length, output free_start,
                    input ready);
    modport sink   (input valid, input action, input length, input free_start,
                    output ready);
endinterface
`default_nettype wire

// ===== design/ffba_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_rsp_if
// Response channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
interface ffba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [ffba_pkg::START_W-1:0]  block_start;

    modport source (output valid, output ok, output block_start, input ready);
    modport sink   (input valid, input ok, input block_start, output ready);
endinterface
`default_nettype wire

// ===== design/ffba_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_datapath
// Occupancy map memory, one-word-a-cycle first-fit scan, range
// read-modify-write, pool size register and result registers.
// ----------------------------------------------------------------------------
module ffba_datapath #(
    parameter int POOL_UNITS = ffba_pkg::POOL_UNITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire ffba_pkg::t_cmd           i_cmd,
    output ffba_pkg::t_sts                o_sts,
    input  wire                           i_action,
    input  wire [ffba_pkg::LEN_W-1:0]     i_length,
    input  wire [ffba_pkg::START_W-1:0]   i_free_start,
    input  wire                           i_cfg_we,
    input  wire [ffba_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                          o_ok,
    output logic [ffba_pkg::START_W-1:0]  o_block_start
);

    localparam int WW  = ffba_pkg::WORD_W;
    localparam int OW  = ffba_pkg::OFF_W;
    localparam int LW  = ffba_pkg::LEN_W;
    localparam int NW  = (POOL_UNITS + WW - 1) / WW;
    localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int XW  = AW + OW;
    localparam int SW  = (XW + 1 > LW + 1) ? XW + 1 : LW + 1;
    localparam logic [SW-1:0] PU = SW'(POOL_UNITS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NW - 1);

    // occupancy map, one bit per unit, 1 = used
    logic [WW-1:0] mem [NW];

    logic [WW-1:0]                 r_rd_data;
    logic [AW-1:0]                 r_rd_word;
    logic                          r_scan_vld;
    logic                          r_mark_vld;
    logic [AW-1:0]                 r_clr_addr;
    logic [ffba_pkg::CFG_W-1:0]    r_pool_size;
    logic [LW-1:0]                 r_len;
    logic [LW-1:0]                 r_run;
    logic [SW-1:0]                 r_limit;
    logic [AW-1:0]                 r_last_word;
    logic [AW-1:0]                 r_scan_addr;
    logic                          r_scan_act;
    logic [AW-1:0]                 r_mk_addr;
    logic                          r_mk_act;
    logic [AW-1:0]                 r_rng_sw;
    logic [AW-1:0]                 r_rng_ew;
    logic [OW-1:0]                 r_rng_lo;
    logic [OW-1:0]                 r_rng_hi;
    logic                          r_rng_set;
    logic                          r_res_ok;
    logic [ffba_pkg::START_W-1:0]  r_res_start;
    logic                          r_o_ok;
    logic [ffba_pkg::START_W-1:0]  r_o_start;

    logic [SW-1:0]  ps_ext;
    logic [SW-1:0]  limit;
    logic [SW-1:0]  lim_m1;
    logic [SW-1:0]  fs_ext;
    logic [SW-1:0]  fe_raw;
    logic [SW-1:0]  fe;
    logic [SW-1:0]  f_last;
    logic           free_empty;
    logic           alloc_empty;

    logic [WW-1:0]  free_w;
    logic [WW-1:0]  th;
    logic [WW-1:0]  win;
    logic [WW-1:0]  match;
    logic [LW-1:0]  need;
    logic           hit;
    logic [OW-1:0]  hit_pos;
    logic [OW:0]    top_run;
    logic [LW-1:0]  n_run;
    logic [XW-1:0]  end_unit;
    logic [SW-1:0]  first;

    logic           scan_re;
    logic           mark_re;
    logic [AW-1:0]  rd_addr;
    logic           we;
    logic [AW-1:0]  wr_addr;
    logic [WW-1:0]  wr_data;
    logic [OW-1:0]  lo_eff;
    logic [OW-1:0]  hi_eff;
    logic [WW-1:0]  mk_mask;

    // request decode: scan limit and clipped free range
    always_comb begin
        ps_ext      = SW'(r_pool_size);
        limit       = (ps_ext > PU) ? PU : ps_ext;
        lim_m1      = limit - SW'(1);
        fs_ext      = SW'(i_free_start);
        fe_raw      = fs_ext + SW'(i_length);
        fe          = (fe_raw > PU) ? PU : fe_raw;
        f_last      = fe - SW'(1);
        free_empty  = (i_length == '0) || (fs_ext >= PU);
        alloc_empty = (i_length == '0) || (limit == '0);
    end

    // window test per bit: the last len units ending here are free
    always_comb begin
        free_w = ~r_rd_data;
        need   = r_len - r_run;
        for (int d = 0; d < WW; d++) begin
            th[d] = (LW'(d) < r_len);
        end
        for (int i = 0; i < WW; i++) begin
            win[i] = 1'b1;
            for (int j = 0; j <= i; j++) begin
                win[i] = win[i] & (free_w[j] | ~th[i - j]);
            end
            match[i] = win[i] && (LW'(i + 1) >= need)
                       && (SW'({r_rd_word, OW'(i)}) < r_limit);
        end
    end

    // lowest matching bit and free run at the top of the word
    always_comb begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = WW - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit     = 1'b1;
                hit_pos = OW'(i);
            end
        end
        top_run = (OW + 1)'(WW);
        for (int i = 0; i < WW; i++) begin
            if (r_rd_data[i]) begin
                top_run = (OW + 1)'(WW - 1 - i);
            end
        end
        n_run    = (r_rd_data == '0) ? (r_run + LW'(WW)) : LW'(top_run);
        end_unit = {r_rd_word, hit_pos};
        first    = SW'(end_unit) + SW'(1) - SW'(r_len);
    end

    // memory port selection and range mask
    always_comb begin
        scan_re = i_cmd.scan && r_scan_act;
        mark_re = i_cmd.mark && r_mk_act;
        rd_addr = mark_re ? r_mk_addr : r_scan_addr;
        lo_eff  = (r_rd_word == r_rng_sw) ? r_rng_lo : '0;
        hi_eff  = (r_rd_word == r_rng_ew) ? r_rng_hi : OW'(WW - 1);
        mk_mask = ({WW{1'b1}} << lo_eff) & ({WW{1'b1}} >> (OW'(WW - 1) - hi_eff));
        we      = i_cmd.clear || r_mark_vld;
        wr_addr = i_cmd.clear ? r_clr_addr : r_rd_word;
        if (i_cmd.clear) begin
            wr_data = '0;
        end else if (r_rng_set) begin
            wr_data = r_rd_data | mk_mask;
        end else begin
            wr_data = r_rd_data & ~mk_mask;
        end
    end

    // occupancy map memory
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (scan_re || mark_re) begin
            r_rd_data <= mem[rd_addr];
        end
        r_rd_word <= rd_addr;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_vld  <= 1'b0;
            r_mark_vld  <= 1'b0;
            r_clr_addr  <= '0;
            r_pool_size <= ffba_pkg::POOL_SIZE_RST;
            r_scan_act  <= 1'b0;
            r_mk_act    <= 1'b0;
        end else begin
            r_scan_vld <= scan_re;
            r_mark_vld <= mark_re;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_we) begin
                r_pool_size <= i_cfg_wdata;
            end
            // scan read issue
            if (i_cmd.load) begin
                r_scan_act <= 1'b1;
            end else if (scan_re && r_scan_addr == r_last_word) begin
                r_scan_act <= 1'b0;
            end
            // range read issue
            if (i_cmd.load) begin
                r_mk_act <= (i_action == ffba_pkg::ACT_FREE) && !free_empty;
            end else if (o_sts.scan_hit) begin
                r_mk_act <= 1'b1;
            end else if (mark_re && r_mk_addr == r_rng_ew) begin
                r_mk_act <= 1'b0;
            end
        end
    end

    // request, scan and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len       <= i_length;
            r_run       <= '0;
            r_limit     <= limit;
            r_last_word <= lim_m1[XW-1:OW];
            r_scan_addr <= '0;
            r_rng_set   <= 1'b0;
            r_rng_sw    <= fs_ext[XW-1:OW];
            r_rng_lo    <= fs_ext[OW-1:0];
            r_rng_ew    <= f_last[XW-1:OW];
            r_rng_hi    <= f_last[OW-1:0];
            r_mk_addr   <= fs_ext[XW-1:OW];
            if (i_action == ffba_pkg::ACT_FREE) begin
                r_res_ok    <= 1'b1;
                r_res_start <= i_free_start;
            end else begin
                r_res_ok    <= 1'b0;
                r_res_start <= '0;
            end
        end else begin
            if (scan_re) begin
                r_scan_addr <= r_scan_addr + AW'(1);
            end
            if (mark_re) begin
                r_mk_addr <= r_mk_addr + AW'(1);
            end
            if (o_sts.scan_hit) begin
                r_res_ok    <= 1'b1;
                r_res_start <= first[ffba_pkg::START_W-1:0];
                r_rng_set   <= 1'b1;
                r_rng_sw    <= first[XW-1:OW];
                r_rng_lo    <= first[OW-1:0];
                r_rng_ew    <= r_rd_word;
                r_rng_hi    <= hit_pos;
                r_mk_addr   <= first[XW-1:OW];
            end else if (i_cmd.scan && r_scan_vld) begin
                r_run <= n_run;
            end
        end
        if (i_cmd.out_load) begin
            r_o_ok    <= r_res_ok;
            r_o_start <= r_res_start;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.clr_last  = (r_clr_addr == LAST_ADDR);
        o_sts.in_free   = (i_action == ffba_pkg::ACT_FREE);
        o_sts.in_empty  = (i_action == ffba_pkg::ACT_FREE) ? free_empty : alloc_empty;
        o_sts.scan_hit  = i_cmd.scan && r_scan_vld && hit;
        o_sts.scan_miss = i_cmd.scan && r_scan_vld && !hit && (r_rd_word == r_last_word);
        o_sts.mark_done = r_mark_vld && (r_rd_word == r_rng_ew);
    end

    assign o_ok          = r_o_ok;
    assign o_block_start = r_o_start;

endmodule
`default_nettype wire

// ===== design/ffba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer for map clearing, scan, range write-back and the output
// register handshake.
// ----------------------------------------------------------------------------
module ffba_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output ffba_pkg::t_cmd       o_cmd,
    input  wire ffba_pkg::t_sts  i_sts
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_MARK  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_vld;
    logic       n_out_vld;
    logic       accept;

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        accept         = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                accept     = i_in_valid;
                o_cmd.load = accept;
                if (accept) begin
                    if (i_sts.in_empty) begin
                        n_state = ST_DONE;
                    end else if (i_sts.in_free) begin
                        n_state = ST_MARK;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_hit) begin
                    n_state = ST_MARK;
                end else if (i_sts.scan_miss) begin
                    n_state = ST_DONE;
                end
            end
            ST_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_sts.mark_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule
`default_nettype wire

// ===== design/first_fit_bitmap_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Allocate: a scan of W_scan map words at 32 units per cycle (up to ceil(min(pool_size,
//   POOL_UNITS)/32)), then write-back of the W_run words spanned by the run; a miss skips it.
// Free: a read-modify-write of the map words in the range; empty requests need no map access.
// One request in flight; a finished word waits in the output register while the next is taken.
// Reset (synchronous, active low) starts a clearing pass over ceil(POOL_UNITS/32) map words
//   (1024 by default) during which no request is accepted; pool_size resets to 20000.
// ----------------------------------------------------------------------------
// first_fit_bitmap_allocator
// First-fit run allocator over a one-bit-per-unit occupancy map held in a
// 32-bit-wide memory.
// ----------------------------------------------------------------------------
module first_fit_bitmap_allocator #(
    parameter int POOL_UNITS = ffba_pkg::POOL_UNITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    ffba_req_if.sink                   i_req,
    ffba_rsp_if.source                 o_rsp,
    input  wire                        i_cfg_we,
    input  wire [ffba_pkg::CFG_W-1:0]  i_cfg_wdata
);

    ffba_pkg::t_cmd cmd;
    ffba_pkg::t_sts sts;

    // sequencer
    ffba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // map and scan datapath
    ffba_datapath #(
        .POOL_UNITS (POOL_UNITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_action      (i_req.action),
        .i_length      (i_req.length),
        .i_free_start  (i_req.free_start),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_ok          (o_rsp.ok),
        .o_block_start (o_rsp.block_start)
    );

endmodule
`default_nettype wire

// ===== sim/first_fit_bitmap_allocator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_bitmap_allocator_checker
// Watches the request, response and pool size ports of the allocator. It keeps
// its own occupancy map and works out the grant for every accepted request
// word, then compares each accepted response word against the oldest grant.
// ----------------------------------------------------------------------------
module first_fit_bitmap_allocator_checker
    import ffba_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    ffba_req_if             i_req,
    ffba_rsp_if             i_rsp,
    input  wire             i_cfg_we,
    input  wire [CFG_W-1:0] i_cfg_wdata,
    output int              o_mismatches,
    output int              o_outstanding
);

    localparam int MAP_UNITS = POOL_UNITS_DEF;

    typedef struct packed {
        logic               ok;
        logic [START_W-1:0] block_start;
    } t_grant;

    // mirror of the occupancy map and the pool size register
    bit               occ_map [0:MAP_UNITS-1];
    logic [CFG_W-1:0] pool_size;
    t_grant           pending_grants [$];
    int               mismatch_count = 0;
    int               outstanding    = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = outstanding;

    // first-fit search on allocate, clipped clear on free
    function automatic t_grant settle_request(input logic act, input logic [LEN_W-1:0] len,
                                              input logic [START_W-1:0] fstart);
        t_grant      grant;
        int unsigned stop;
        int unsigned scan_span;
        int unsigned run;
        int unsigned first;
        grant = '0;
        if (act == ACT_FREE) begin
            stop = int'(fstart) + int'(len);
            if (stop > MAP_UNITS) stop = MAP_UNITS;
            for (int unsigned u = fstart; u < stop; u++) occ_map[u] = 1'b0;
            grant.ok          = 1'b1;
            grant.block_start = fstart;
            return grant;
        end
        scan_span = pool_size;
        if (scan_span > MAP_UNITS) scan_span = MAP_UNITS;
        if (len == '0) return grant;
        run = 0;
        for (int unsigned u = 0; u < scan_span; u++) begin
            if (occ_map[u]) begin
                run = 0;
            end else begin
                run++;
                if (run == len) begin
                    first = u + 1 - len;
                    for (int unsigned v = first; v <= u; v++) occ_map[v] = 1'b1;
                    grant.ok          = 1'b1;
                    grant.block_start = first[START_W-1:0];
                    return grant;
                end
            end
        end
        return grant;
    endfunction

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            for (int u = 0; u < MAP_UNITS; u++) occ_map[u] = 1'b0;
            pool_size = POOL_SIZE_RST;
            pending_grants.delete();
        end else begin
            if (i_cfg_we) pool_size = i_cfg_wdata;
            // response word against the oldest grant
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_grants.size() == 0) begin
                    $error("response word with no request outstanding: ok %0d block_start %0d",
                           i_rsp.ok, i_rsp.block_start);
                    mismatch_count++;
                end else begin
                    want = pending_grants.pop_front();
                    if (i_rsp.ok !== want.ok) begin
                        $error("ok: expected %0d, actual %0d", want.ok, i_rsp.ok);
                        mismatch_count++;
                    end
                    if (i_rsp.block_start !== want.block_start) begin
                        $error("block_start: expected %0d, actual %0d",
                               want.block_start, i_rsp.block_start);
                        mismatch_count++;
                    end
                end
            end
            // request word updates the map at once
            if (i_req.valid && i_req.ready) begin
                want = settle_request(i_req.action, i_req.length, i_req.free_start);
                pending_grants.push_back(want);
            end
        end
        outstanding <= pending_grants.size();
    end

endmodule

// ===== sim/first_fit_bitmap_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_bitmap_allocator_test
// Drives allocate and free words into the allocator: a directed set around the
// fit, clip and pool size corner cases, then random phases over several pool
// sizes, with random idling on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module first_fit_bitmap_allocator_test;
    import ffba_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int MAP_UNITS   = POOL_UNITS_DEF;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int HOLD_AT     = 260;
    localparam int HOLD_CYCLES = 1500;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    int mismatch_count;
    int outstanding;
    int pool_units  = POOL_SIZE_RST;
    int words_sent  = 0;
    int words_taken = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int cycle_count = 0;

    ffba_req_if req_ch ();
    ffba_rsp_if rsp_ch ();

    first_fit_bitmap_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    first_fit_bitmap_allocator_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatch_count),
        .o_outstanding (outstanding)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("first_fit_bitmap_allocator verification failed");
            $finish;
        end
    end

    // response side: random stalls, a quiet stretch and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) words_taken <= words_taken + 1;
            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end else if (words_taken == HOLD_AT && !hold_done) begin
                hold_done    <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end else if (words_taken >= 320 && words_taken < 420) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= 12);
            end
        end
    end

    // one request word, with a random gap ahead of it outside the quiet stretch
    task automatic send_word(input logic act, input logic [LEN_W-1:0] len,
                             input logic [START_W-1:0] fstart);
        int gap;
        if ((words_sent < 200 || words_sent >= 300) && $urandom_range(0, 99) < 12) begin
            req_ch.valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.length     <= len;
        req_ch.free_start <= fstart;
        do @(posedge i_clk); while (!req_ch.ready);
        words_sent++;
    endtask

    // wait until every grant has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic set_pool_size(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
        pool_units = value;
    endtask

    // mostly short runs, now and then up to a sixth of the pool
    function automatic logic [LEN_W-1:0] short_length(input int span);
        int top_len;
        top_len = span / 6;
        if (top_len < 1) top_len = 1;
        if (top_len > 4096) top_len = 4096;
        if ($urandom_range(0, 1) == 0 && top_len > 8) top_len = 8;
        return LEN_W'($urandom_range(1, top_len));
    endfunction

    // random words within the pool, plus a share of malformed ones
    task automatic random_phase(input int n_words);
        int                 span;
        int                 pick;
        logic [START_W-1:0] fstart;
        span = (pool_units > MAP_UNITS) ? MAP_UNITS : pool_units;
        if (span < 1) span = 1;
        send_word(ACT_FREE, '1, '0);
        for (int i = 0; i < n_words; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 56) begin
                send_word(ACT_ALLOC, short_length(span), START_W'($urandom));
            end else if (pick < 92) begin
                fstart = START_W'($urandom_range(0, span - 1));
                send_word(ACT_FREE, short_length(span), fstart);
            end else begin
                case (pick % 4)
                    0: send_word(ACT_ALLOC, '0, START_W'($urandom));
                    1: send_word(ACT_ALLOC, LEN_W'($urandom), START_W'($urandom));
                    2: send_word(ACT_FREE, LEN_W'($urandom), START_W'($urandom));
                    default: send_word(ACT_FREE, '0, START_W'($urandom));
                endcase
            end
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.action     <= ACT_ALLOC;
        req_ch.length     <= '0;
        req_ch.free_start <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset pool size: fits, word crossings, zero length, clipping
        send_word(ACT_ALLOC, 16'd0, '0);
        send_word(ACT_ALLOC, 16'd1, '0);
        send_word(ACT_ALLOC, 16'd31, '0);
        send_word(ACT_ALLOC, 16'd40, '0);
        send_word(ACT_FREE, 16'd5, 15'd1);
        send_word(ACT_ALLOC, 16'd3, '1);
        send_word(ACT_ALLOC, 16'hFFFF, '0);
        send_word(ACT_FREE, 16'd0, 15'd0);
        send_word(ACT_ALLOC, 16'd20000, '0);
        send_word(ACT_FREE, 16'hFFFF, 15'd0);
        send_word(ACT_ALLOC, 16'd20000, '0);
        send_word(ACT_ALLOC, 16'd1, '0);
        send_word(ACT_FREE, 16'hFFFF, 15'd32767);
        send_word(ACT_FREE, 16'd3, 15'd5);
        send_word(ACT_FREE, 16'd3, 15'd5);
        send_word(ACT_ALLOC, 16'd4, '0);
        send_word(ACT_ALLOC, 16'd3, '0);

        // empty pool
        set_pool_size(16'd0);
        send_word(ACT_ALLOC, 16'd1, '0);

        // pool size beyond the map
        set_pool_size(16'hFFFF);
        send_word(ACT_FREE, 16'hFFFF, 15'd0);
        send_word(ACT_ALLOC, 16'd32768, '0);
        send_word(ACT_ALLOC, 16'd1, '0);
        send_word(ACT_FREE, 16'd8, 15'd32760);
        send_word(ACT_ALLOC, 16'd8, '0);

        // single unit pool
        set_pool_size(16'd1);
        send_word(ACT_FREE, 16'd1, 15'd0);
        send_word(ACT_ALLOC, 16'd1, '0);
        send_word(ACT_ALLOC, 16'd1, '0);

        // random phases over several pool sizes
        set_pool_size(16'd64);
        random_phase(60);
        set_pool_size(CFG_W'($urandom_range(1, 48)));
        random_phase(50);
        set_pool_size(16'd700);
        random_phase(150);
        set_pool_size(CFG_W'($urandom_range(2000, 6000)));
        random_phase(130);
        set_pool_size(16'd32768);
        random_phase(100);
        set_pool_size(16'hFFFF);
        random_phase(50);

        drain_results();
        repeat (64) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("first_fit_bitmap_allocator verification clean");
        end else begin
            $display("first_fit_bitmap_allocator verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ffba_pkg.sv
design/ffba_req_if.sv
design/ffba_rsp_if.sv
design/ffba_datapath.sv
design/ffba_ctrl.sv
design/first_fit_bitmap_allocator.sv
sim/first_fit_bitmap_allocator_checker.sv
sim/first_fit_bitmap_allocator_test.sv
